// ===== hw/rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer and unmasker.
// Used by every module of the block; depends on nothing.
package wsd_pkg;

  // Width of the declared payload length that the parser keeps.
  localparam int LengthBits = 32;
  localparam int EffBits    = (LengthBits < 32) ? LengthBits : 32;

  // Saturated length used when the declared length does not fit.
  localparam logic [31:0] SatLen = 32'hFFFF_FFFF >> (32 - EffBits);

  // Reset value of the length limit register.
  localparam logic [31:0] LimitReset = 32'd2048;

  // Header field constants.
  localparam logic [6:0] LenCode16  = 7'd126;
  localparam logic [6:0] LenCode64  = 7'd127;
  localparam logic [3:0] OpClose    = 4'd8;
  localparam logic [2:0] Ext16Bytes = 3'd2;
  localparam logic [2:0] KeyBytes   = 3'd4;

  // Parser phase, one-hot.
  typedef enum logic [5:0] {
    PH_HDR0  = 6'b000001,
    PH_HDR1  = 6'b000010,
    PH_EXT16 = 6'b000100,
    PH_EXT64 = 6'b001000,
    PH_MASK  = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_t;

  // One result item as it travels from the parser to the output register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       empty_frame;
    logic [3:0] frame_opcode;
    logic       fin_bit;
    logic       close_frame;
    logic       oversize;
  } result_t;

  // Handshake between the stages: a byte is present, and the byte that is held.
  typedef struct packed {
    logic       byte_valid;
    logic [7:0] byte_data;
  } in_stage_t;

endpackage

// ===== hw/rtl/wsd_in_stage.sv =====
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on wsd_pkg for the stage struct.
module wsd_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               take,
  output wsd_pkg::in_stage_t stage
);

  logic       vld;
  logic [7:0] byte_q;

  // Stall upstream only while a held byte cannot move on.
  assign in_stall = vld && !take;

  // Load a new transfer whenever the register is free or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (!in_stall) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_q <= rx_byte;
    end
  end

  assign stage.byte_valid = vld;
  assign stage.byte_data  = byte_q;

endmodule

// ===== hw/rtl/wsd_parser.sv =====
// Frame parser: header state machine, length and key capture, unmasking XOR.
// Depends on wsd_pkg for the phase type, result struct and constants.
module wsd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [31:0]        length_limit,
  input  wsd_pkg::in_stage_t stage,
  input  logic               step,
  output logic               emit,
  output wsd_pkg::result_t   res
);

  wsd_pkg::phase_t phase, phase_next;
  logic [2:0]  hc, hc_next;
  logic [3:0]  opcode_reg, opcode_next;
  logic        fin_reg, fin_next;
  logic [31:0] acc, acc_next;
  logic        ovf, ovf_next;
  logic [31:0] key, key_next;
  logic [31:0] remaining, remaining_next;
  logic [1:0]  idx, idx_next;
  logic [31:0] limit;

  logic [7:0]  b;
  logic [31:0] fin_acc_in;
  logic        fin_ovf_in;
  logic        fin_ovf;
  logic [31:0] fin_acc;
  logic [7:0]  key_byte;
  logic        is_last;
  logic        oversize;

  assign b = stage.byte_data;

  // Length limit register; the user must write it only while the block is idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= wsd_pkg::LimitReset;
    end else if (cfg_valid) begin
      limit <= length_limit;
    end
  end

  // Close of the length field: range check and saturation.
  always_comb begin
    fin_ovf = fin_ovf_in;
    if (wsd_pkg::EffBits < 32 && (fin_acc_in >> wsd_pkg::EffBits) != 32'd0) begin
      fin_ovf = 1'b1;
    end
    fin_acc = fin_ovf ? wsd_pkg::SatLen : fin_acc_in;
  end

  // Key byte for the current payload position, first key byte in the top bits.
  always_comb begin
    unique case (idx)
      2'd0:    key_byte = key[31:24];
      2'd1:    key_byte = key[23:16];
      2'd2:    key_byte = key[15:8];
      default: key_byte = key[7:0];
    endcase
  end

  assign is_last  = (remaining == 32'd1);
  assign oversize = ovf || (acc > limit);

  // Next-state and result logic for one byte.
  always_comb begin
    phase_next     = phase;
    hc_next        = hc;
    opcode_next    = opcode_reg;
    fin_next       = fin_reg;
    acc_next       = acc;
    ovf_next       = ovf;
    key_next       = key;
    remaining_next = remaining;
    idx_next       = idx;
    fin_acc_in     = {25'd0, b[6:0]};
    fin_ovf_in     = 1'b0;
    emit           = 1'b0;
    res.data_byte    = 8'd0;
    res.is_last      = 1'b0;
    res.empty_frame  = 1'b0;
    res.frame_opcode = opcode_reg;
    res.fin_bit      = fin_reg;
    res.close_frame  = (opcode_reg == wsd_pkg::OpClose);
    res.oversize     = oversize;

    unique case (phase)
      wsd_pkg::PH_HDR1: begin
        acc_next = 32'd0;
        ovf_next = 1'b0;
        hc_next  = 3'd0;
        if (b[6:0] == wsd_pkg::LenCode16) begin
          phase_next = wsd_pkg::PH_EXT16;
        end else if (b[6:0] == wsd_pkg::LenCode64) begin
          phase_next = wsd_pkg::PH_EXT64;
        end else begin
          fin_acc_in     = {25'd0, b[6:0]};
          fin_ovf_in     = 1'b0;
          acc_next       = fin_acc;
          ovf_next       = fin_ovf;
          remaining_next = fin_acc;
          key_next       = 32'd0;
          phase_next     = wsd_pkg::PH_MASK;
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        fin_acc_in = {acc[23:0], b};
        fin_ovf_in = ovf || (acc[31:24] != 8'd0);
        acc_next   = fin_acc_in;
        ovf_next   = fin_ovf_in;
        hc_next    = hc + 3'd1;
        if ((phase == wsd_pkg::PH_EXT16 && hc_next == wsd_pkg::Ext16Bytes) ||
            (phase == wsd_pkg::PH_EXT64 && hc_next == 3'd0)) begin
          acc_next       = fin_acc;
          ovf_next       = fin_ovf;
          remaining_next = fin_acc;
          hc_next        = 3'd0;
          key_next       = 32'd0;
          phase_next     = wsd_pkg::PH_MASK;
        end
      end
      wsd_pkg::PH_MASK: begin
        key_next = {key[23:0], b};
        hc_next  = hc + 3'd1;
        if (hc_next == wsd_pkg::KeyBytes) begin
          hc_next  = 3'd0;
          idx_next = 2'd0;
          if (remaining == 32'd0) begin
            // A frame with no payload yields one empty result.
            phase_next      = wsd_pkg::PH_HDR0;
            emit            = 1'b1;
            res.is_last     = 1'b1;
            res.empty_frame = 1'b1;
          end else begin
            phase_next = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_DATA: begin
        emit           = 1'b1;
        res.data_byte  = b ^ key_byte;
        res.is_last    = is_last;
        idx_next       = idx + 2'd1;
        remaining_next = remaining - 32'd1;
        if (is_last) begin
          phase_next = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        // First header byte; unused codes land here as well.
        fin_next    = b[7];
        opcode_next = b[3:0];
        hc_next     = 3'd0;
        phase_next  = wsd_pkg::PH_HDR1;
      end
    endcase

    if (!step) begin
      emit = 1'b0;
    end
  end

  // Parser state registers advance once per byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= wsd_pkg::PH_HDR0;
      hc         <= 3'd0;
      opcode_reg <= 4'd0;
      fin_reg    <= 1'b0;
      acc        <= 32'd0;
      ovf        <= 1'b0;
      key        <= 32'd0;
      remaining  <= 32'd0;
      idx        <= 2'd0;
    end else if (step) begin
      phase      <= phase_next;
      hc         <= hc_next;
      opcode_reg <= opcode_next;
      fin_reg    <= fin_next;
      acc        <= acc_next;
      ovf        <= ovf_next;
      key        <= key_next;
      remaining  <= remaining_next;
      idx        <= idx_next;
    end
  end

endmodule

// ===== hw/rtl/wsd_out_stage.sv =====
// Output register of the deframer: holds one result until downstream takes it.
// Depends on wsd_pkg for the result struct.
module wsd_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             emit,
  input  wsd_pkg::result_t res,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             can_load,
  output wsd_pkg::result_t held
);

  // The register accepts a new result when empty or being drained this cycle.
  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && emit) begin
      held <= res;
    end
  end

endmodule

// ===== hw/rtl/websocket_frame_deframer_unmask_top.sv =====
// Top level of the WebSocket frame deframer and unmasker.
// Depends on wsd_pkg, wsd_in_stage, wsd_parser and wsd_out_stage.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid/in_stall    rx_byte
//   out      output     out_valid/out_stall  data_byte .. oversize
//   cfg      input      cfg_valid/cfg_ready  length_limit
//
// One byte per cycle while the output does not stall: a byte sits in the input register,
// the parser updates its state and forms a result combinationally, and the result lands
// in the output register. Reset is synchronous on rst and returns the parser to the first
// header byte. A stalled output holds its result and backs up into the input register.
module websocket_frame_deframer_unmask_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  data_byte,
  output logic        is_last,
  output logic        empty_frame,
  output logic [3:0]  frame_opcode,
  output logic        fin_bit,
  output logic        close_frame,
  output logic        oversize,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] length_limit
);

  wsd_pkg::in_stage_t stage;
  wsd_pkg::result_t   res;
  wsd_pkg::result_t   held;
  logic               can_load;
  logic               step;
  logic               emit;

  assign cfg_ready = 1'b1;
  assign step      = stage.byte_valid && can_load;

  wsd_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .take     (can_load),
    .stage    (stage)
  );

  wsd_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .length_limit (length_limit),
    .stage        (stage),
    .step         (step),
    .emit         (emit),
    .res          (res)
  );

  wsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .emit      (emit),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .can_load  (can_load),
    .held      (held)
  );

  // Result fields to their ports.
  assign data_byte    = held.data_byte;
  assign is_last      = held.is_last;
  assign empty_frame  = held.empty_frame;
  assign frame_opcode = held.frame_opcode;
  assign fin_bit      = held.fin_bit;
  assign close_frame  = held.close_frame;
  assign oversize     = held.oversize;

endmodule

// ===== tb/websocket_frame_deframer_unmask_checker.sv =====
// Scoreboard for the WebSocket frame deframer: it tracks the frame parser on every
// input transfer and compares each output transfer with the oldest predicted result.
// Depends on wsd_pkg for the phase encoding, the result layout and the header constants.
module websocket_frame_deframer_unmask_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  input  logic        empty_frame,
  input  logic [3:0]  frame_opcode,
  input  logic        fin_bit,
  input  logic        close_frame,
  input  logic        oversize,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] length_limit,
  output int          errors,
  output int          outstanding
);

  // Parser state as seen from the byte stream.
  wsd_pkg::phase_t parse_phase;
  logic [2:0]  hdr_cnt;
  logic [3:0]  op_q;
  logic        fin_q;
  logic [31:0] declared_len;
  logic        len_ovf;
  logic [31:0] key_q;
  logic [31:0] bytes_left;
  logic [1:0]  key_pos;
  logic [31:0] limit_q;

  // Unmasked results that are still due on the output channel, oldest first.
  wsd_pkg::result_t predicted_q[$];
  int          fail_cnt = 0;
  int          backlog = 0;

  assign errors      = fail_cnt;
  assign outstanding = backlog;

  // Close out the header once the declared length is complete and move to the key.
  function automatic void end_of_length();
    if (wsd_pkg::EffBits < 32 && (declared_len >> wsd_pkg::EffBits) != 0) len_ovf = 1'b1;
    if (len_ovf) declared_len = wsd_pkg::SatLen;
    bytes_left  = declared_len;
    hdr_cnt     = '0;
    key_q       = '0;
    parse_phase = wsd_pkg::PH_MASK;
  endfunction

  // Build a result from the current frame header; oversize uses the limit in force now.
  function automatic wsd_pkg::result_t make_result(input logic [7:0] data, input logic last,
                                                   input logic empty);
    wsd_pkg::result_t r;
    r.data_byte    = data;
    r.is_last      = last;
    r.empty_frame  = empty;
    r.frame_opcode = op_q;
    r.fin_bit      = fin_q;
    r.close_frame  = (op_q == wsd_pkg::OpClose);
    r.oversize     = len_ovf || (declared_len > limit_q);
    return r;
  endfunction

  // Advance the parser by one received byte; returns 1 when the byte yields a result.
  function automatic bit unmask_step(input logic [7:0] b, output wsd_pkg::result_t r);
    logic [6:0] code;
    logic [7:0] key_byte;
    logic       last;
    bit         got;
    r   = '0;
    got = 1'b0;
    case (parse_phase)
      wsd_pkg::PH_HDR1: begin
        code         = b[6:0];
        declared_len = '0;
        len_ovf      = 1'b0;
        hdr_cnt      = '0;
        if (code == wsd_pkg::LenCode16) begin
          parse_phase = wsd_pkg::PH_EXT16;
        end else if (code == wsd_pkg::LenCode64) begin
          parse_phase = wsd_pkg::PH_EXT64;
        end else begin
          declared_len = 32'(code);
          end_of_length();
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        // A byte shifted out of the top means the length does not fit.
        if (declared_len[31:24] != 0) len_ovf = 1'b1;
        declared_len = {declared_len[23:0], b};
        hdr_cnt      = hdr_cnt + 3'd1;
        if ((parse_phase == wsd_pkg::PH_EXT16 && hdr_cnt == wsd_pkg::Ext16Bytes) ||
            (parse_phase == wsd_pkg::PH_EXT64 && hdr_cnt == 3'd0)) begin
          end_of_length();
        end
      end
      wsd_pkg::PH_MASK: begin
        key_q   = {key_q[23:0], b};
        hdr_cnt = hdr_cnt + 3'd1;
        if (hdr_cnt == wsd_pkg::KeyBytes) begin
          hdr_cnt = '0;
          key_pos = '0;
          // A frame without payload reports itself once its key is complete.
          if (bytes_left == 0) begin
            parse_phase = wsd_pkg::PH_HDR0;
            r           = make_result(8'h00, 1'b1, 1'b1);
            got         = 1'b1;
          end else begin
            parse_phase = wsd_pkg::PH_DATA;
          end
        end
      end
      wsd_pkg::PH_DATA: begin
        key_byte   = key_q[8 * (3 - int'(key_pos)) +: 8];
        last       = (bytes_left == 32'd1);
        r          = make_result(b ^ key_byte, last, 1'b0);
        got        = 1'b1;
        key_pos    = key_pos + 2'd1;
        bytes_left = bytes_left - 32'd1;
        if (last) parse_phase = wsd_pkg::PH_HDR0;
      end
      default: begin
        // The first header byte; unused phase codes land here as well.
        fin_q       = b[7];
        op_q        = b[3:0];
        hdr_cnt     = '0;
        parse_phase = wsd_pkg::PH_HDR1;
      end
    endcase
    return got;
  endfunction

  // Report one field that differs from its prediction.
  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want_v, got_v);
      fail_cnt++;
    end
  endtask

  // Watch the three channels; results leave the queue before new ones join it.
  always @(posedge clk) begin : monitor
    wsd_pkg::result_t want;
    if (rst) begin
      parse_phase  = wsd_pkg::PH_HDR0;
      hdr_cnt      = '0;
      op_q         = '0;
      fin_q        = 1'b0;
      declared_len = '0;
      len_ovf      = 1'b0;
      key_q        = '0;
      bytes_left   = '0;
      key_pos      = '0;
      limit_q      = wsd_pkg::LimitReset;
      predicted_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) limit_q = length_limit;
      if (out_valid && !out_stall) begin
        if (predicted_q.size() == 0) begin
          $error("result transfer with nothing predicted: data_byte %0d", data_byte);
          fail_cnt++;
        end else begin
          want = predicted_q.pop_front();
          check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
          check_field("is_last", 32'(want.is_last), 32'(is_last));
          check_field("empty_frame", 32'(want.empty_frame), 32'(empty_frame));
          check_field("frame_opcode", 32'(want.frame_opcode), 32'(frame_opcode));
          check_field("fin_bit", 32'(want.fin_bit), 32'(fin_bit));
          check_field("close_frame", 32'(want.close_frame), 32'(close_frame));
          check_field("oversize", 32'(want.oversize), 32'(oversize));
        end
      end
      if (in_valid && !in_stall) begin
        if (unmask_step(rx_byte, want)) predicted_q.push_back(want);
      end
    end
    backlog <= predicted_q.size();
  end

endmodule

// ===== tb/tb_websocket_frame_deframer_unmask_top.sv =====
// Testbench top for the WebSocket frame deframer: clock, reset, frame stimulus,
// output back-pressure, length limit writes and the final verdict.
// Depends on wsd_pkg, websocket_frame_deframer_unmask_top and the checker module.
module tb_websocket_frame_deframer_unmask_top;

  localparam int CycleLimit    = 600000;
  localparam int HoldOffCycles = 150;
  localparam int DrainPad      = 4;
  localparam int RandomBytes   = 800;

  // How the payload length is encoded in the header.
  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  data_byte;
  logic        is_last;
  logic        empty_frame;
  logic [3:0]  frame_opcode;
  logic        fin_bit;
  logic        close_frame;
  logic        oversize;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] length_limit = '0;

  int errors;
  int outstanding;
  int cycle_cnt = 0;
  int sent_bytes = 0;
  int hold_off_reqs = 0;
  bit quiet = 1'b0;

  websocket_frame_deframer_unmask_top dut (.*);

  websocket_frame_deframer_unmask_checker checker_i (.*);

  // Free-running clock with a period of 8.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a run that hangs or loses results ends here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long; none in quiet stretches.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pick a length limit, extremes included.
  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return wsd_pkg::LimitReset;
      3: return $urandom_range(0, 64);
      4: return $urandom_range(0, 300);
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int served;
    int run;
    served = 0;
    @(posedge clk);
    forever begin
      if (hold_off_reqs != served) begin
        served++;
        out_stall <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
      end else begin
        run = gap_len();
        if (run > 0) begin
          out_stall <= 1'b1;
          repeat (run) @(posedge clk);
        end
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Offer one byte after a random gap and hold it until the transfer happens.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  // Stop sending and wait until every predicted result has been taken.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainPad) @(posedge clk);
  endtask

  // One write of the length limit register; only called while the block is idle.
  task automatic write_limit(input logic [31:0] value);
    cfg_valid    <= 1'b1;
    length_limit <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Send one masked frame. At payload index split_at the stream pauses and the
  // limit is rewritten mid-frame; a negative split_at means no pause.
  task automatic send_frame(input logic [7:0] head, input len_form_t form,
                            input logic [63:0] len_field, input int body,
                            input int split_at);
    logic [31:0] key;
    logic [6:0]  code;
    key = $urandom;
    case (form)
      LEN_EXT16: code = wsd_pkg::LenCode16;
      LEN_EXT64: code = wsd_pkg::LenCode64;
      default:   code = len_field[6:0];
    endcase
    send_byte(head);
    send_byte({1'($urandom_range(0, 1)), code});
    if (form == LEN_EXT16) begin
      for (int i = 1; i >= 0; i--) send_byte(len_field[8 * i +: 8]);
    end
    if (form == LEN_EXT64) begin
      for (int i = 7; i >= 0; i--) send_byte(len_field[8 * i +: 8]);
    end
    for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    for (int i = 0; i < body; i++) begin
      if (i == split_at) begin
        wait_idle();
        write_limit(pick_limit());
      end
      send_byte(8'($urandom));
    end
  endtask

  // A well-formed frame with random header, encoding, size and payload.
  task automatic random_frame();
    int roll;
    int n;
    int split;
    len_form_t form;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      form = LEN_SHORT;
      n    = $urandom_range(0, 6);
    end else if (roll < 70) begin
      form = LEN_SHORT;
      n    = $urandom_range(7, 125);
    end else if (roll < 85) begin
      form = LEN_EXT16;
      n    = $urandom_range(0, 160);
    end else begin
      form = LEN_EXT64;
      n    = $urandom_range(0, 160);
    end
    split = (n > 1 && $urandom_range(0, 99) < 8) ? $urandom_range(1, n - 1) : -1;
    send_frame(8'($urandom), form, 64'(n), n, split);
  endtask

  // Stimulus: directed frames, random phases with limit changes, then an overlong frame.
  initial begin : stimulus
    int target;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A zero-length close frame, then an extended-length frame with the RSV bits
    // set, both against a zero limit.
    write_limit('0);
    send_frame(8'h88, LEN_SHORT, 64'd0, 0, -1);
    send_frame(8'h71, LEN_EXT16, 64'd1, 1, -1);
    // Every header bit set, 64-bit length, and the limit rewritten mid-frame.
    send_frame(8'hFF, LEN_EXT64, 64'd2, 2, 1);

    // Random phases; the limit changes between them and the sender drains each time.
    target = sent_bytes + RandomBytes;
    for (int p = 0; sent_bytes < target; p++) begin
      wait_idle();
      write_limit((p == 1) ? '1 : (p == 2) ? '0 : pick_limit());
      quiet <= (p % 4 == 3);
      if (p == 2 || p == 5) hold_off_reqs <= hold_off_reqs + 1;
      repeat ($urandom_range(2, 5)) random_frame();
    end

    // A declared length beyond 32 bits saturates; this frame never ends, so it goes last.
    wait_idle();
    write_limit(pick_limit());
    quiet <= 1'b0;
    send_frame(8'($urandom), LEN_EXT64, {32'($urandom) | 32'd1, 32'($urandom)}, 24, -1);

    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
